>>> rtl/fsa_pkg.sv
package fsa_pkg;

	localparam int DSD = 64;
	localparam int RSD = 64;
	localparam int DAW = 6;
	localparam int RAW = 6;
	localparam int CNTW = 7;

	typedef enum logic [5:0] {
		OP_LIT = 6'd0, OP_ADD = 6'd1, OP_SUB = 6'd2, OP_MUL = 6'd3, OP_DIV = 6'd4,
		OP_MOD = 6'd5, OP_DIVMOD = 6'd6, OP_NEG = 6'd7, OP_ABS = 6'd8, OP_MIN = 6'd9,
		OP_MAX = 6'd10, OP_DUP = 6'd11, OP_DROP = 6'd12, OP_SWAP = 6'd13,
		OP_OVER = 6'd14, OP_ROT = 6'd15, OP_MROT = 6'd16, OP_NIP = 6'd17,
		OP_TUCK = 6'd18, OP_PICK = 6'd19, OP_ROLL = 6'd20, OP_2DUP = 6'd21,
		OP_2DROP = 6'd22, OP_2SWAP = 6'd23, OP_2OVER = 6'd24, OP_AND = 6'd25,
		OP_OR = 6'd26, OP_XOR = 6'd27, OP_INV = 6'd28, OP_LSH = 6'd29,
		OP_RSH = 6'd30, OP_EQ = 6'd31, OP_NE = 6'd32, OP_LT = 6'd33, OP_GT = 6'd34,
		OP_LE = 6'd35, OP_GE = 6'd36, OP_ZEQ = 6'd37, OP_ZLT = 6'd38,
		OP_ZGT = 6'd39, OP_TOR = 6'd40, OP_RFROM = 6'd41, OP_RFETCH = 6'd42,
		OP_NOP = 6'd63
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_UNDER = 2'd2, ST_OVER = 2'd3
	} status_t;

	// Unit commands for the shared ALU.
	typedef enum logic [1:0] {
		ALU_IDLE = 2'd0, ALU_MUL = 2'd1, ALU_DIV = 2'd2
	} alu_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RDW, S_CHK, S_IDX, S_IDXW, S_EXEC,
		S_ALU, S_WR, S_ROLL_RD, S_ROLL_RDW, S_ROLL_WR, S_ROLL_LAST, S_OUT0,
		S_OUT1, S_OUTW, S_DONE
	} state_t;

	typedef struct packed {
		logic       start;
		alu_cmd_t   cmd;
	} alu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quo;
		logic [63:0] rem;
	} alu_rsp_t;

	// Operand needs and results per opcode.
	function automatic logic [2:0] need_d(input logic [5:0] op);
		case (op)
			OP_LIT, OP_RFROM, OP_RFETCH: need_d = 3'd0;
			OP_NEG, OP_ABS, OP_DUP, OP_DROP, OP_PICK, OP_ROLL, OP_INV, OP_ZEQ,
			OP_ZLT, OP_ZGT, OP_TOR: need_d = 3'd1;
			OP_ROT, OP_MROT: need_d = 3'd3;
			OP_2SWAP, OP_2OVER: need_d = 3'd4;
			default: need_d = 3'd2;
		endcase
	endfunction

	function automatic logic [2:0] give_d(input logic [5:0] op);
		case (op)
			OP_DROP, OP_ROLL, OP_2DROP, OP_TOR: give_d = 3'd0;
			OP_DIVMOD, OP_DUP, OP_SWAP: give_d = 3'd2;
			OP_OVER, OP_ROT, OP_MROT, OP_TUCK: give_d = 3'd3;
			OP_2DUP, OP_2SWAP: give_d = 3'd4;
			OP_2OVER: give_d = 3'd6;
			default: give_d = 3'd1;
		endcase
	endfunction

endpackage

>>> rtl/fsa_alu.sv
module fsa_alu
	import fsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output alu_rsp_t    rsp
);

	// One shared unit: a radix-2 restoring divider on magnitudes, and a
	// 64x64 multiplier built from three 32x32 partial products over cycles.
	logic        busy_q, done_q;
	alu_cmd_t    cmd_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q, quo_q, div_q, acc_q;
	logic        nq_q, nr_q;
	logic [63:0] ma, mb;
	logic [64:0] trial;
	logic [31:0] pa, pb;
	logic [63:0] prod;

	assign ma = a[63] ? 64'(-a) : a;
	assign mb = b[63] ? 64'(-b) : b;
	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin pa = a[31:0]; pb = b[31:0]; end
			2'd1: begin pa = a[63:32]; pb = b[31:0]; end
			2'd2: begin pa = a[31:0]; pb = b[63:32]; end
			default: begin pa = a[63:32]; pb = b[63:32]; end
		endcase
	end
	assign prod = pa * pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cmd_q  <= ALU_IDLE;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cmd_q  <= req.cmd;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= ma;
				div_q  <= mb;
				acc_q  <= '0;
				nq_q   <= a[63] ^ b[63];
				nr_q   <= a[63];
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cmd_q == ALU_MUL) begin
					case (cnt_q[1:0])
						2'd0: acc_q <= prod;
						2'd1: acc_q <= acc_q + {prod[31:0], 32'd0};
						2'd2: acc_q <= acc_q + {prod[31:0], 32'd0};
						default: acc_q <= acc_q;
					endcase
					if (cnt_q[1:0] == 2'd2) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					if (cnt_q == 7'd63) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (cmd_q == ALU_MUL) begin
			rsp.quo = acc_q;
			rsp.rem = '0;
		end else begin
			rsp.quo = nq_q ? 64'(-quo_q) : quo_q;
			rsp.rem = nr_q ? 64'(-rem_q) : rem_q;
		end
	end

endmodule

>>> rtl/fsa_ram.sv
module fsa_ram
	import fsa_pkg::*;
(
	input  logic           clk,
	input  logic           we,
	input  logic [DAW-1:0] waddr,
	input  logic [63:0]    wdata,
	input  logic [DAW-1:0] raddr,
	output logic [63:0]    rdata
);

	logic [63:0] mem [DSD];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/forth_stack_alu.sv
// Forth primitive executor on a 64-entry data stack and a 64-entry return
// stack, both held in single-port-read RAMs.
// Slave channel s_axis_*: one beat is one primitive; tdata carries opcode
// and literal. Master channel m_axis_*: one beat per primitive with the
// top two data entries, both depths, a status code and the sticky divide
// flag. Results come out in order, one for each accepted beat.
// A beat is processed by a sequencer that reads operands from the data
// stack RAM one a cycle, runs the shared ALU, and writes results back one
// a cycle. Multiply, and divide, mod and divmod by a non-zero divisor,
// wait in the shared ALU; pick and roll first fetch the index, and roll
// then moves each entry above the rolled one down in turn.
// s_axis_tready is high only while the sequencer is idle; the result sits
// in an output register, so the sequencer is freed once it is loaded and
// the next beat may be taken while the receiver stalls.
// Reset clears both depths, the sticky flag and the sequencer; stack RAM
// contents are not cleared and only entries below the depth are used.
module forth_stack_alu
	import fsa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [71:0]   s_axis_tdata,  // opcode[5:0], literal[69:6], zero pad
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [151:0]  m_axis_tdata   // top, second, data_count,
	                                     // return_count, step_status,
	                                     // divide_error_seen, zero pad
);

	state_t st_q, st_d;
	logic [5:0]  op_q;
	logic [63:0] lit_q;
	logic [CNTW-1:0] dd_q, rd_q;
	logic        sticky_q;
	status_t     stat_q;
	logic [63:0] a_q [4];
	logic [63:0] res_q [6];
	logic [2:0]  k_q;
	logic [2:0]  nd, pd;
	logic [CNTW-1:0] base;
	logic [DAW:0] idx_q, j_q;
	logic [63:0] rv_q, top_q, sec_q;
	logic        ovalid_q;
	logic [151:0] odata_q;
	logic [63:0] x, y;
	logic        idx_bad;

	// Data stack RAM ports.
	logic           dwe;
	logic [DAW-1:0] dwa, dra;
	logic [63:0]    dwd, drd;
	// Return stack RAM ports.
	logic           rwe;
	logic [RAW-1:0] rwa, rra;
	logic [63:0]    rwd, rrd;

	alu_req_t areq;
	alu_rsp_t arsp;

	fsa_ram u_dram (.clk, .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(drd));
	fsa_ram u_rram (.clk, .we(rwe), .waddr(rwa), .wdata(rwd), .raddr(rra), .rdata(rrd));
	fsa_alu u_alu (.clk, .arst_n, .req(areq), .a(a_q[0]), .b(a_q[1]), .rsp(arsp));

	assign nd   = need_d(op_q);
	assign pd   = give_d(op_q);
	assign base = dd_q - CNTW'(nd);
	assign x    = a_q[0];
	assign y    = a_q[1];

	// The pick/roll index must be non-negative and below depth-1.
	assign idx_bad = drd[63] || (drd >= 64'(dd_q - CNTW'(1)));

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;

	function automatic logic [63:0] flg(input logic c);
		flg = c ? '1 : '0;
	endfunction

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (s_axis_tvalid) st_d = S_CHK;
			S_CHK: begin
				if (op_q > 6'd42) st_d = S_OUT0;
				else if (dd_q < CNTW'(nd)
					|| ((op_q == OP_RFROM || op_q == OP_RFETCH) && rd_q == '0))
					st_d = S_OUT0;
				else if (op_q == OP_PICK || op_q == OP_ROLL) st_d = S_IDX;
				else if (CNTW'(base) + CNTW'(pd) > CNTW'(DSD)
					|| (op_q == OP_TOR && rd_q == CNTW'(RSD))) st_d = S_OUT0;
				else if (nd != 3'd0) st_d = S_RD0;
				else st_d = S_RDW;
			end
			S_IDX: st_d = S_IDXW;
			S_IDXW: st_d = idx_bad ? S_OUT0 : S_RD0;
			S_RD0: st_d = S_RD1;
			S_RD1: st_d = (k_q + 3'd2 >= nd) ? S_RDW : S_RD1;
			S_RDW: st_d = S_EXEC;
			S_EXEC: begin
				if ((op_q == OP_MUL) || ((op_q == OP_DIV || op_q == OP_MOD
					|| op_q == OP_DIVMOD) && y != '0)) st_d = S_ALU;
				else if (op_q == OP_ROLL) st_d = (j_q == '0) ? S_ROLL_LAST : S_ROLL_RD;
				else st_d = S_WR;
			end
			S_ALU: if (arsp.done) st_d = S_WR;
			S_ROLL_RD: st_d = S_ROLL_RDW;
			S_ROLL_RDW: st_d = S_ROLL_WR;
			S_ROLL_WR: st_d = (j_q == '0) ? S_ROLL_LAST : S_ROLL_RD;
			S_ROLL_LAST: st_d = S_OUT0;
			S_WR: st_d = (k_q + 3'd1 >= pd || pd == 3'd0) ? S_OUT0 : S_WR;
			S_OUT0: st_d = S_OUT1;
			S_OUT1: st_d = S_OUTW;
			S_OUTW: st_d = S_DONE;
			S_DONE: if (!ovalid_q || m_axis_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// RAM and ALU control.
	always_comb begin
		dwe  = 1'b0;
		dwa  = '0;
		dwd  = '0;
		dra  = '0;
		rwe  = 1'b0;
		rwa  = rd_q[RAW-1:0];
		rwd  = x;
		rra  = RAW'(rd_q - CNTW'(1));
		areq.start = 1'b0;
		areq.cmd   = (op_q == OP_MUL) ? ALU_MUL : ALU_DIV;
		case (st_q)
			S_IDX: dra = DAW'(dd_q - CNTW'(1));
			// Pick and roll fetch the indexed entry in place of the top.
			S_RD0: dra = (op_q == OP_PICK || op_q == OP_ROLL) ? DAW'(idx_q) : DAW'(base);
			S_RD1: dra = DAW'(base + CNTW'(k_q) + CNTW'(1));
			S_ROLL_RD, S_ROLL_RDW: dra = DAW'(idx_q + 7'd1);
			S_OUT0: dra = DAW'(dd_q - CNTW'(1));
			S_OUT1: dra = DAW'(dd_q - CNTW'(2));
			S_EXEC: begin
				areq.start = (st_d == S_ALU);
				rwe = (op_q == OP_TOR);
			end
			S_WR: begin
				dwe = (pd != 3'd0);
				dwa = DAW'(base + CNTW'(k_q));
				dwd = res_q[k_q];
			end
			S_ROLL_WR: begin
				dwe = 1'b1;
				dwa = DAW'(idx_q);
				dwd = drd;
			end
			S_ROLL_LAST: begin
				dwe = 1'b1;
				dwa = DAW'(dd_q - CNTW'(2));
				dwd = rv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			dd_q     <= '0;
			rd_q     <= '0;
			sticky_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_DONE && st_d == S_IDLE) ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					op_q   <= s_axis_tdata[5:0];
					lit_q  <= s_axis_tdata[69:6];
					stat_q <= ST_OK;
					k_q    <= '0;
				end
				S_CHK: begin
					if (op_q <= 6'd42 && st_d == S_OUT0) begin
						if (dd_q < CNTW'(nd)
							|| ((op_q == OP_RFROM || op_q == OP_RFETCH) && rd_q == '0))
							stat_q <= ST_UNDER;
						else stat_q <= ST_OVER;
					end
				end
				S_IDXW: begin
					if (idx_bad) begin
						stat_q <= ST_UNDER;
					end else begin
						idx_q <= (DAW+1)'(dd_q - CNTW'(2) - CNTW'(drd[DAW:0]));
						j_q   <= (DAW+1)'(drd[DAW:0]);
					end
				end
				S_RD1: begin
					a_q[k_q[1:0]] <= drd;
					k_q <= k_q + 3'd1;
				end
				S_RDW: begin
					if (k_q < nd) a_q[k_q[1:0]] <= drd;
					k_q <= '0;
				end
				S_EXEC: begin
					case (op_q)
						OP_LIT: res_q[0] <= lit_q;
						OP_ADD: res_q[0] <= x + y;
						OP_SUB: res_q[0] <= x - y;
						OP_DIV, OP_MOD, OP_DIVMOD: if (y == '0) begin
							sticky_q <= 1'b1;
							stat_q   <= ST_DIV0;
							res_q[0] <= '0;
							res_q[1] <= '0;
						end
						OP_NEG: res_q[0] <= -x;
						OP_ABS: res_q[0] <= x[63] ? -x : x;
						OP_MIN: res_q[0] <= ($signed(x) < $signed(y)) ? x : y;
						OP_MAX: res_q[0] <= ($signed(y) < $signed(x)) ? x : y;
						OP_DUP: begin res_q[0] <= x; res_q[1] <= x; end
						OP_SWAP: begin res_q[0] <= y; res_q[1] <= x; end
						OP_OVER: begin res_q[0] <= x; res_q[1] <= y; res_q[2] <= x; end
						OP_ROT: begin res_q[0] <= y; res_q[1] <= a_q[2]; res_q[2] <= x; end
						OP_MROT: begin res_q[0] <= a_q[2]; res_q[1] <= x; res_q[2] <= y; end
						OP_NIP: res_q[0] <= y;
						OP_TUCK: begin res_q[0] <= y; res_q[1] <= x; res_q[2] <= y; end
						OP_PICK: res_q[0] <= x;
						OP_ROLL: rv_q <= x;
						OP_2DUP: begin
							res_q[0] <= x; res_q[1] <= y; res_q[2] <= x; res_q[3] <= y;
						end
						OP_2SWAP: begin
							res_q[0] <= a_q[2]; res_q[1] <= a_q[3];
							res_q[2] <= x; res_q[3] <= y;
						end
						OP_2OVER: begin
							res_q[0] <= x; res_q[1] <= y; res_q[2] <= a_q[2];
							res_q[3] <= a_q[3]; res_q[4] <= x; res_q[5] <= y;
						end
						OP_AND: res_q[0] <= x & y;
						OP_OR: res_q[0] <= x | y;
						OP_XOR: res_q[0] <= x ^ y;
						OP_INV: res_q[0] <= ~x;
						OP_LSH: res_q[0] <= (y >= 64'd64) ? '0 : x << y[5:0];
						OP_RSH: res_q[0] <= (y >= 64'd64) ? '0 : x >> y[5:0];
						OP_EQ: res_q[0] <= flg(x == y);
						OP_NE: res_q[0] <= flg(x != y);
						OP_LT: res_q[0] <= flg($signed(x) < $signed(y));
						OP_GT: res_q[0] <= flg($signed(y) < $signed(x));
						OP_LE: res_q[0] <= flg(!($signed(y) < $signed(x)));
						OP_GE: res_q[0] <= flg(!($signed(x) < $signed(y)));
						OP_ZEQ: res_q[0] <= flg(x == '0);
						OP_ZLT: res_q[0] <= flg(x[63]);
						OP_ZGT: res_q[0] <= flg(x != '0 && !x[63]);
						OP_TOR: rd_q <= rd_q + CNTW'(1);
						OP_RFROM: begin res_q[0] <= rrd; rd_q <= rd_q - CNTW'(1); end
						OP_RFETCH: res_q[0] <= rrd;
						default: ;
					endcase
				end
				S_ALU: if (arsp.done) begin
					case (op_q)
						OP_MUL, OP_DIV: res_q[0] <= arsp.quo;
						OP_MOD: res_q[0] <= arsp.rem;
						default: begin res_q[0] <= arsp.rem; res_q[1] <= arsp.quo; end
					endcase
				end
				S_ROLL_WR: begin
					idx_q <= idx_q + 7'd1;
					j_q   <= j_q - 7'd1;
				end
				S_ROLL_LAST: dd_q <= dd_q - CNTW'(1);
				S_WR: begin
					k_q <= k_q + 3'd1;
					if (st_d == S_OUT0) dd_q <= base + CNTW'(pd);
				end
				S_OUT1: top_q <= (dd_q >= CNTW'(1)) ? drd : '0;
				S_DONE: if (st_d == S_IDLE) begin
					odata_q  <= {7'd0, sticky_q, stat_q, rd_q, dd_q,
						(dd_q >= CNTW'(2)) ? sec_q : 64'd0, top_q};
				end
				default: ;
			endcase
		end
	end

	// The second entry's read lands in the cycle after the top's; hold it in sec_q.
	always_ff @(posedge clk) begin
		if (st_q == S_OUTW) sec_q <= drd;
	end

endmodule

>>> tb/forth_stack_alu_tb.sv
`timescale 1ns / 100ps

module forth_stack_alu_tb;
	import fsa_pkg::*;

	localparam int ITEM_TARGET = 1800;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

	typedef struct {
		logic [5:0]  opcode;
		logic [63:0] literal;
		bit          drain_first;
	} prim_t;

	typedef struct {
		logic [63:0] top;
		logic [63:0] second;
		logic [6:0]  dcount;
		logic [6:0]  rcount;
		status_t     status;
		logic        div_seen;
	} snap_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [151:0] m_axis_tdata;

	prim_t prim_q[$];
	snap_t snap_q[$];

	// Shadow machine state used to work out each expected beat.
	logic [63:0] dstk[DSD];
	logic [63:0] rstk[RSD];
	int dpth;
	int rpth;
	logic div_flag;

	int total_prims;
	int sent;
	int rcvd;
	int errors;
	int cycles;
	int gap;
	int stall;
	int status_hits[4];

	forth_stack_alu u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int operands_needed(logic [5:0] op);
		case (op)
			OP_LIT, OP_RFROM, OP_RFETCH: return 0;
			OP_NEG, OP_ABS, OP_DUP, OP_DROP, OP_PICK, OP_ROLL, OP_INV, OP_ZEQ,
			OP_ZLT, OP_ZGT, OP_TOR: return 1;
			OP_ROT, OP_MROT: return 3;
			OP_2SWAP, OP_2OVER: return 4;
			default: return 2;
		endcase
	endfunction

	function automatic int results_pushed(logic [5:0] op);
		case (op)
			OP_DROP, OP_ROLL, OP_2DROP, OP_TOR: return 0;
			OP_DIVMOD, OP_DUP, OP_SWAP: return 2;
			OP_OVER, OP_ROT, OP_MROT, OP_TUCK: return 3;
			OP_2DUP, OP_2SWAP: return 4;
			OP_2OVER: return 6;
			default: return 1;
		endcase
	endfunction

	function automatic logic [63:0] truth(bit c);
		return c ? '1 : '0;
	endfunction

	// Runs one primitive on the shadow stacks and returns the beat it should give.
	task automatic execute_primitive(input logic [5:0] op, input logic [63:0] lit,
			output snap_t s);
		int nd, pd, nr, pr, base, idx;
		logic [63:0] a[4];
		logic [63:0] res[6];
		logic [63:0] x, y, n, q, r, v;
		status_t st;
		st = ST_OK;
		n = '0;
		if (op <= OP_RFETCH) begin
			nd = operands_needed(op);
			pd = results_pushed(op);
			nr = (op == OP_RFROM || op == OP_RFETCH) ? 1 : 0;
			pr = (op == OP_TOR || op == OP_RFETCH) ? 1 : 0;
			if (dpth < nd || rpth < nr) begin
				st = ST_UNDER;
			end else if (op == OP_PICK || op == OP_ROLL) begin
				n = dstk[dpth - 1];
				if (n >= 64'(dpth - 1))
					st = ST_UNDER;
			end
			if (st == ST_OK && (dpth - nd + pd > DSD || rpth - nr + pr > RSD))
				st = ST_OVER;
			if (st == ST_OK) begin
				base = dpth - nd;
				foreach (a[i]) a[i] = (i < nd) ? dstk[base + i] : '0;
				foreach (res[i]) res[i] = '0;
				x = a[0];
				y = a[1];
				case (op)
					OP_LIT: res[0] = lit;
					OP_ADD: res[0] = x + y;
					OP_SUB: res[0] = x - y;
					OP_MUL: res[0] = x * y;
					OP_DIV, OP_MOD, OP_DIVMOD: begin
						if (y == '0) begin
							div_flag = 1'b1;
							st = ST_DIV0;
						end else begin
							if (x == MOST_NEG && y == '1) begin
								q = MOST_NEG;
								r = '0;
							end else begin
								q = $signed(x) / $signed(y);
								r = $signed(x) % $signed(y);
							end
							if (op == OP_DIV) res[0] = q;
							else if (op == OP_MOD) res[0] = r;
							else begin
								res[0] = r;
								res[1] = q;
							end
						end
					end
					OP_NEG: res[0] = -x;
					OP_ABS: res[0] = x[63] ? -x : x;
					OP_MIN: res[0] = ($signed(x) < $signed(y)) ? x : y;
					OP_MAX: res[0] = ($signed(y) < $signed(x)) ? x : y;
					OP_DUP: begin res[0] = x; res[1] = x; end
					OP_SWAP: begin res[0] = y; res[1] = x; end
					OP_OVER: begin res[0] = x; res[1] = y; res[2] = x; end
					OP_ROT: begin res[0] = y; res[1] = a[2]; res[2] = x; end
					OP_MROT: begin res[0] = a[2]; res[1] = x; res[2] = y; end
					OP_NIP: res[0] = y;
					OP_TUCK: begin res[0] = y; res[1] = x; res[2] = y; end
					OP_PICK: res[0] = dstk[base - 1 - int'(n)];
					OP_ROLL: begin
						idx = base - 1 - int'(n);
						v = dstk[idx];
						for (int j = idx; j + 1 < base; j++)
							dstk[j] = dstk[j + 1];
						dstk[base - 1] = v;
					end
					OP_2DUP: begin res[0] = x; res[1] = y; res[2] = x; res[3] = y; end
					OP_2SWAP: begin
						res[0] = a[2]; res[1] = a[3]; res[2] = x; res[3] = y;
					end
					OP_2OVER: begin
						res[0] = x; res[1] = y; res[2] = a[2]; res[3] = a[3];
						res[4] = x; res[5] = y;
					end
					OP_AND: res[0] = x & y;
					OP_OR: res[0] = x | y;
					OP_XOR: res[0] = x ^ y;
					OP_INV: res[0] = ~x;
					OP_LSH: res[0] = (y >= 64) ? '0 : x << y[5:0];
					OP_RSH: res[0] = (y >= 64) ? '0 : x >> y[5:0];
					OP_EQ: res[0] = truth(x == y);
					OP_NE: res[0] = truth(x != y);
					OP_LT: res[0] = truth($signed(x) < $signed(y));
					OP_GT: res[0] = truth($signed(y) < $signed(x));
					OP_LE: res[0] = truth(!($signed(y) < $signed(x)));
					OP_GE: res[0] = truth(!($signed(x) < $signed(y)));
					OP_ZEQ: res[0] = truth(x == '0);
					OP_ZLT: res[0] = truth(x[63]);
					OP_ZGT: res[0] = truth(x != '0 && !x[63]);
					OP_TOR: begin
						rstk[rpth] = x;
						rpth++;
					end
					OP_RFROM: begin
						rpth--;
						res[0] = rstk[rpth];
					end
					OP_RFETCH: res[0] = rstk[rpth - 1];
					default: ;
				endcase
				for (int i = 0; i < pd; i++)
					dstk[base + i] = res[i];
				dpth = base + pd;
			end
		end
		s.top = (dpth >= 1) ? dstk[dpth - 1] : '0;
		s.second = (dpth >= 2) ? dstk[dpth - 2] : '0;
		s.dcount = 7'(dpth);
		s.rcount = 7'(rpth);
		s.status = st;
		s.div_seen = div_flag;
	endtask

	task automatic queue_primitive(input logic [5:0] op, input logic [63:0] lit,
			input bit drain = 0);
		prim_t p;
		snap_t s;
		p.opcode = op;
		p.literal = lit;
		p.drain_first = drain;
		execute_primitive(op, lit, s);
		prim_q.push_back(p);
		snap_q.push_back(s);
		total_prims++;
	endtask

	function automatic logic [63:0] pick_literal();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 64'($urandom_range(0, 70));
			4: return -64'($urandom_range(1, 8));
			5: return '0;
			6: return MOST_POS;
			7: return MOST_NEG;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", rcvd, field, got, want);
		errors++;
	endtask

	initial begin
		int mode;
		int roll;
		logic [5:0] op;
		arst_n = 1'b0;
		total_prims = 0;
		dpth = 0;
		rpth = 0;
		div_flag = 1'b0;

		// Opening corner cases: empty-stack underflow, wrap of the most negative
		// value, divide by zero, oversized shift and a bad pick index.
		queue_primitive(OP_ADD, '0);
		queue_primitive(OP_RFROM, '0);
		queue_primitive(OP_LIT, MOST_NEG);
		queue_primitive(OP_ABS, '0);
		queue_primitive(OP_NEG, '0);
		queue_primitive(OP_LIT, '1);
		queue_primitive(OP_DIVMOD, '0);
		queue_primitive(OP_LIT, '0);
		queue_primitive(OP_MOD, '0);
		queue_primitive(OP_LIT, 64'd64);
		queue_primitive(OP_LSH, '0);
		queue_primitive(OP_LIT, MOST_POS);
		queue_primitive(OP_LIT, 64'd63);
		queue_primitive(OP_RSH, '0);
		queue_primitive(OP_LIT, 64'd9);
		queue_primitive(OP_PICK, '0);
		queue_primitive(OP_LIT, -64'd7);
		queue_primitive(OP_LIT, 64'd2);
		queue_primitive(OP_DIV, '0);
		queue_primitive(OP_LIT, -64'd7);
		queue_primitive(OP_LIT, 64'd2);
		queue_primitive(OP_MOD, '0);
		queue_primitive(OP_NOP, '0);
		queue_primitive(6'd43, '0);

		mode = 0;
		while (total_prims < ITEM_TARGET) begin
			if (total_prims % 60 == 0)
				mode = $urandom_range(0, 3);
			roll = $urandom_range(0, 99);
			op = 6'($urandom_range(OP_ADD, OP_RFETCH));
			case (mode)
				1: if (roll < 60) op = OP_LIT;
				2: if (roll < 15) op = OP_LIT;
				3: begin
					if (roll < 30) op = OP_TOR;
					else if (roll < 50) op = OP_RFROM;
					else if (roll < 60) op = OP_RFETCH;
					else if (roll < 80) op = OP_LIT;
				end
				default: begin
					if (roll < 35) op = OP_LIT;
					else if (roll < 40) op = 6'($urandom_range(43, 63));
				end
			endcase
			// Most index and shift operands are set up to be meaningful.
			if ((op == OP_PICK || op == OP_ROLL) && dpth >= 1 && $urandom_range(0, 5) != 0)
				queue_primitive(OP_LIT, ($urandom_range(0, 7) == 0) ?
					64'(dpth + $urandom_range(0, 3)) : 64'($urandom_range(0, dpth - 1)));
			else if ((op == OP_LSH || op == OP_RSH) && $urandom_range(0, 2) != 0)
				queue_primitive(OP_LIT, 64'($urandom_range(0, 70)));
			queue_primitive(op, (op == OP_LIT) ? pick_literal() : {$urandom, $urandom},
				total_prims >= ITEM_TARGET / 2 && total_prims < ITEM_TARGET / 2 + 2);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (rcvd == total_prims);
		repeat (100) @(posedge clk);
		$display("%0d primitives checked: %0d ok, %0d divide by zero, %0d underflow, %0d overflow",
			rcvd, status_hits[ST_OK], status_hits[ST_DIV0], status_hits[ST_UNDER],
			status_hits[ST_OVER]);
		if (errors == 0 && snap_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout with %0d results outstanding", snap_q.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Sender: feeds primitives from the pending queue with bursts of idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			sent <= 0;
			gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				sent <= sent + 1;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (prim_q.size() > 0 && prim_q.size() > 150
						&& $urandom_range(0, 9) == 0) begin
					gap <= $urandom_range(0, 16);
					s_axis_tvalid <= 1'b0;
				end else if (prim_q.size() > 0 && !(prim_q[0].drain_first
						&& rcvd != sent + (s_axis_tvalid && s_axis_tready))) begin
					s_axis_tdata <= {2'b00, prim_q[0].literal, prim_q[0].opcode};
					s_axis_tvalid <= 1'b1;
					void'(prim_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts, then checks each beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		snap_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rcvd <= 0;
			errors = 0;
			stall <= 0;
			foreach (status_hits[i]) status_hits[i] <= 0;
		end else begin
			if (stall > 0) begin
				stall <= stall - 1;
				m_axis_tready <= 1'b0;
			end else if (total_prims - rcvd > 150 && $urandom_range(0, 9) == 0) begin
				stall <= $urandom_range(0, 16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				rcvd <= rcvd + 1;
				if (snap_q.size() == 0) begin
					$display("result beat %0d arrived with nothing expected", rcvd);
					errors++;
				end else begin
					want = snap_q.pop_front();
					status_hits[want.status] <= status_hits[want.status] + 1;
					if (m_axis_tdata[63:0] !== want.top)
						report("top_value", m_axis_tdata[63:0], want.top);
					if (m_axis_tdata[127:64] !== want.second)
						report("second_value", m_axis_tdata[127:64], want.second);
					if (m_axis_tdata[134:128] !== want.dcount)
						report("data_count", 64'(m_axis_tdata[134:128]), 64'(want.dcount));
					if (m_axis_tdata[141:135] !== want.rcount)
						report("return_count", 64'(m_axis_tdata[141:135]), 64'(want.rcount));
					if (m_axis_tdata[143:142] !== want.status)
						report("step_status", 64'(m_axis_tdata[143:142]), 64'(want.status));
					if (m_axis_tdata[144] !== want.div_seen)
						report("divide_error_seen", 64'(m_axis_tdata[144]), 64'(want.div_seen));
				end
			end
		end
	end

endmodule
